### hw/rtl/bmdq_pkg.sv
// Shared types and codes for the bounded message deque.
package bmdq_pkg;

  // Command codes carried by an input word
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLOSE      = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OccW    = 7;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Input word
  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [ValueW-1:0] entry_value;
  } in_t;

  // Result word
  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] popped_value;
    logic [OccW-1:0]   occupancy;
  } out_t;

  // Registered response from the controller, popped data excluded
  typedef struct packed {
    status_e         status;
    logic            pop_ok;
    logic [OccW-1:0] occupancy;
  } resp_t;

endpackage

### hw/rtl/bounded_message_deque.sv
// Top level of the bounded message deque: config register, controller, memory.
//
// Bounded double-ended queue of message handles. Each input word is one
// command (push back, push front, pop front, pop back, close) and yields
// exactly one result word with a status, the popped handle and the count
// held afterward. Handles live in a single-port synchronous memory of
// QUEUE_DEPTH entries; the front index, count and open flag sit in flops.
// The result of a word appears in the cycle after it is accepted (the memory
// read data is registered), and the block accepts one word per cycle as long
// as the result side takes each result; a stalled result holds the input side.
// Full and empty do not stall: they come back as a status. The entry_limit
// register (byte address 0) caps the count; zero selects QUEUE_DEPTH.
// Write it only while the block is idle.
module bounded_message_deque #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmdq_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmdq_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmdq_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bmdq_pkg::ApbDataW-1:0]  pwdata,
  output logic [bmdq_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import bmdq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  logic [LimitW-1:0]      limit_q;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        mem_addr;
  logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;
  logic [63:0]            rdata_ext;
  resp_t                  resp;
  logic                   reg_sel;

  // Decode the single limit register
  assign reg_sel = (paddr[ApbAddrW-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? ApbDataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  bmdq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .limit_i     (limit_q),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .resp_o      (resp)
  );

  bmdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (HANDLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Assemble the result word; drop popped data unless a pop succeeded
  assign rdata_ext = 64'(mem_rdata);
  always_comb begin
    out_data_o.status       = resp.status;
    out_data_o.popped_value = resp.pop_ok ? rdata_ext[ValueW-1:0] : '0;
    out_data_o.occupancy    = resp.occupancy;
  end

endmodule

### hw/rtl/bmdq_store.sv
// Single-port synchronous handle memory with registered read data.
module bmdq_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on push, read on pop; one access per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bmdq_ctrl.sv
// Deque controller: front index, count, open flag and memory access issue.
module bmdq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 32,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bmdq_pkg::in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [bmdq_pkg::LimitW-1:0] limit_i,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic [IdxW-1:0]       mem_addr_o,
  output logic [HANDLE_BITS-1:0] mem_wdata_o,
  output bmdq_pkg::resp_t       resp_o
);
  import bmdq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = IdxW + 2;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic            open_q, open_d;
  logic            valid_q;
  resp_t           resp_q, resp_d;

  logic            accept;
  logic            we, re;
  logic [IdxW-1:0] addr;
  logic [CntW-1:0] lim_act;
  logic [SumW-1:0] back_pos;
  logic [63:0]     val_ext;
  logic [31:0]     cnt_ext;
  status_e         status;
  logic            pop_ok;

  // Fold a position below twice the depth into a slot
  function automatic logic [IdxW-1:0] wrap_slot(input logic [SumW-1:0] pos);
    logic [SumW-1:0] p;
    p = pos;
    if (p >= SumW'(QUEUE_DEPTH)) begin
      p = p - SumW'(QUEUE_DEPTH);
    end
    return p[IdxW-1:0];
  endfunction

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~valid_q | out_ready_i;

  // Active limit: zero or above depth selects the depth
  always_comb begin
    if (limit_i == '0 || 32'(limit_i) > 32'(QUEUE_DEPTH)) begin
      lim_act = CntW'(QUEUE_DEPTH);
    end else begin
      lim_act = CntW'(limit_i);
    end
  end

  assign back_pos = SumW'(front_q) + SumW'(count_q);
  assign val_ext  = 64'(in_data_i.entry_value);

  // Decode the command and compute next state
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    open_d  = open_q;
    status  = ST_DONE;
    pop_ok  = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    addr    = front_q;
    unique case (cmd_e'(in_data_i.command))
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (!open_q) begin
          status = ST_CLOSED;
        end else if (count_q >= lim_act) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (cmd_e'(in_data_i.command) == CMD_PUSH_BACK) begin
            addr = wrap_slot(back_pos);
          end else begin
            front_d = (front_q == '0) ? IdxW'(QUEUE_DEPTH - 1) : front_q - 1'b1;
            addr    = front_d;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (!open_q) begin
          status = ST_CLOSED;
        end else if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          re      = 1'b1;
          pop_ok  = 1'b1;
          count_d = count_q - 1'b1;
          if (cmd_e'(in_data_i.command) == CMD_POP_FRONT) begin
            addr    = front_q;
            front_d = wrap_slot(SumW'(front_q) + SumW'(1));
          end else begin
            addr = wrap_slot(back_pos - SumW'(1));
          end
        end
      end
      CMD_CLOSE: begin
        if (!open_q) begin
          status = ST_CLOSED;
        end
        open_d = 1'b0;
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign cnt_ext = 32'(count_d);
  always_comb begin
    resp_d.status    = status;
    resp_d.pop_ok    = pop_ok;
    resp_d.occupancy = cnt_ext[OccW-1:0];
  end

  // Advance queue state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      open_q  <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
        open_q  <= open_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      resp_q <= resp_d;
    end
  end

  assign mem_we_o    = accept & we;
  assign mem_re_o    = accept & re;
  assign mem_addr_o  = addr;
  assign mem_wdata_o = val_ext[HANDLE_BITS-1:0];
  assign out_valid_o = valid_q;
  assign resp_o      = resp_q;

endmodule
